// ----- rtl/cjt_pkg.sv -----
// shared types and constants of the cubic joint trajectory generator
package cjt_pkg;

   localparam int MAX_JOINTS_DEF = 8;
   localparam int QUEUE_DEPTH    = 2;

   localparam int DIV_NW = 85;
   localparam int DIV_DW = 41;
   localparam int DIV_CW = 7;

   localparam logic FUNC_TICK = 1'b1;

   // 3 * 10^6 for the velocity bound, 6 * 10^12 for the acceleration bound
   localparam logic [21:0] VEL_SCALE = 22'd3000000;
   localparam logic [42:0] ACC_SCALE = 43'd6000000000000;

   localparam logic [16:0] S_ONE = 17'h10000;

   localparam logic [DIV_CW-1:0] TV_ITERS = 7'd54;
   localparam logic [DIV_CW-1:0] TA_ITERS = 7'd85;
   localparam logic [DIV_CW-1:0] S_ITERS  = 7'd56;
   localparam logic [5:0]        SQRT_STEPS = 6'd40;

   typedef struct packed {
      logic               func;
      logic [39:0]        time_now;
      logic [2:0]         joint_index;
      logic signed [31:0] start_angle;
      logic signed [31:0] end_angle;
      logic [30:0]        vel_limit;
      logic [30:0]        acc_limit;
   } req_type;

   typedef struct packed {
      logic [2:0]         joint_out;
      logic signed [31:0] command_angle;
      logic               last_joint;
   } rsp_type;

   typedef struct packed {
      logic               is_tick;
      logic               new_ref;
      logic               in_range;
      logic [2:0]         joint;
      logic [39:0]        time_now;
      logic signed [31:0] start_angle;
      logic signed [31:0] end_angle;
      logic [31:0]        delta_abs;
      logic [30:0]        vel;
      logic [30:0]        acc;
   } cmd_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
      logic [DIV_CW-1:0] iters;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quot;
   } div_rsp_type;

endpackage

// ----- rtl/cjt_queue.sv -----
// small register-based first-in first-out queue
module cjt_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/cjt_divider.sv -----
// shared restoring divider, one quotient bit per cycle
module cjt_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  cjt_pkg::div_req_type req,
   output cjt_pkg::div_rsp_type rsp
);

   logic [cjt_pkg::DIV_NW-1:0] num_ff, num_in, quot_ff, quot_in;
   logic [cjt_pkg::DIV_DW-1:0] den_ff, den_in;
   logic [cjt_pkg::DIV_DW:0]   rem_ff, rem_in, trial;
   logic [cjt_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic                       ge;

   assign trial = {rem_ff[cjt_pkg::DIV_DW-1:0], num_ff[cjt_pkg::DIV_NW-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.num;
         den_in  = req.den;
         cnt_in  = req.iters;
         quot_in = '0;
         rem_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? trial - {1'b0, den_ff} : trial;
         quot_in = {quot_ff[cjt_pkg::DIV_NW-2:0], ge};
         num_in  = {num_ff[cjt_pkg::DIV_NW-2:0], 1'b0};
         cnt_in  = cnt_ff - cjt_pkg::DIV_CW'(1);
         if (cnt_ff == cjt_pkg::DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// ----- rtl/cjt_front.sv -----
// front end: takes requests, classifies them and queues them for the back end
module cjt_front #(
   parameter int MAX_JOINTS = cjt_pkg::MAX_JOINTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cjt_pkg::req_type req_item,
   input  logic             cmd_pop,
   output logic             cmd_empty,
   output cjt_pkg::cmd_type cmd_head
);

   cjt_pkg::cmd_type   cmd;
   logic signed [32:0] diff;
   logic [32:0]        mag;

   assign diff = $signed({req_item.end_angle[31], req_item.end_angle})
               - $signed({req_item.start_angle[31], req_item.start_angle});
   assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

   always_comb begin
      cmd.is_tick     = (req_item.func == cjt_pkg::FUNC_TICK);
      cmd.new_ref     = (req_item.joint_index == 3'd0);
      cmd.in_range    = (int'(req_item.joint_index) < MAX_JOINTS);
      cmd.joint       = req_item.joint_index;
      cmd.time_now    = req_item.time_now;
      cmd.start_angle = req_item.start_angle;
      cmd.end_angle   = req_item.end_angle;
      cmd.delta_abs   = mag[31:0];
      // a zero limit counts as the smallest step
      cmd.vel         = (req_item.vel_limit == '0) ? 31'd1 : req_item.vel_limit;
      cmd.acc         = (req_item.acc_limit == '0) ? 31'd1 : req_item.acc_limit;
   end

   cjt_queue #(
      .WIDTH ($bits(cjt_pkg::cmd_type)),
      .DEPTH (cjt_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_head)
   );

endmodule

// ----- rtl/cjt_back.sv -----
// back end: duration planning on loads and per-joint setpoints on ticks
module cjt_back #(
   parameter int MAX_JOINTS = cjt_pkg::MAX_JOINTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   input  cjt_pkg::cmd_type     cmd_head,
   output cjt_pkg::div_req_type div_req,
   input  cjt_pkg::div_rsp_type div_rsp,
   input  logic                 out_full,
   output logic                 out_push,
   output cjt_pkg::rsp_type     out_item
);

   localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int LW = $clog2(MAX_JOINTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LD_MUL, ST_LD_MUL_HI, ST_LD_WAIT_V, ST_LD_DIV_A, ST_LD_WAIT_A,
      ST_LD_SQRT, ST_LD_FIN, ST_TK_SUB, ST_TK_CLASS, ST_TK_WAIT, ST_TK_SQ,
      ST_TK_CUBE, ST_TK_BLEND, ST_TK_MUL, ST_TK_EMIT
   } state_type;

   state_type          state_ff, state_in;
   cjt_pkg::cmd_type   cmd_ff, cmd_in;
   logic signed [31:0] start_mem_ff [MAX_JOINTS];
   logic signed [31:0] end_mem_ff [MAX_JOINTS];
   logic [MAX_JOINTS-1:0] valid_ff, valid_in;
   logic [LW-1:0]      loaded_ff, loaded_in;
   logic [39:0]        start_time_ff, start_time_in, duration_ff, duration_in;
   logic [53:0]        pv_ff, pv_in, tv_ff, tv_in;
   logic [63:0]        plo_ff, plo_in;
   logic [42:0]        phi_ff, phi_in;
   logic [79:0]        rad_ff, rad_in;
   logic [39:0]        root_ff, root_in;
   logic [42:0]        srem_ff, srem_in;
   logic [5:0]         scnt_ff, scnt_in;
   logic [39:0]        el_ff, el_in;
   logic               early_ff, early_in;
   logic [16:0]        s_ff, s_in, b_ff, b_in;
   logic [33:0]        s2_ff, s2_in;
   logic [50:0]        s3_ff, s3_in;
   logic [JW-1:0]      idx_ff, idx_in;
   logic signed [31:0] q0_ff, q0_in;
   logic signed [50:0] p_ff, p_in;

   logic               mem_we;
   logic [JW-1:0]      widx;
   logic [MAX_JOINTS-1:0] wsel, base_valid;
   logic [LW-1:0]      base_loaded, j1;
   logic [42:0]        sq_trial, sq_sub;
   logic [39:0]        tv_sat, tj;
   logic [52:0]        blend;
   logic signed [31:0] rd_q0, rd_qf;
   logic signed [17:0] bs;
   logic signed [32:0] dq;
   logic signed [50:0] prod;
   logic               last;

   assign widx        = JW'(cmd_head.joint);
   assign wsel        = MAX_JOINTS'(1) << widx;
   assign base_valid  = cmd_head.new_ref ? '0 : valid_ff;
   assign base_loaded = cmd_head.new_ref ? '0 : loaded_ff;
   assign j1          = LW'(cmd_head.joint) + LW'(1);

   // one root bit per step of the digit-by-digit square root
   assign sq_trial = {srem_ff[40:0], rad_ff[79:78]};
   assign sq_sub   = {1'b0, root_ff, 2'b01};

   assign tv_sat = (|tv_ff[53:40]) ? '1 : tv_ff[39:0];
   assign tj     = (root_ff > tv_sat) ? root_ff : tv_sat;
   assign blend  = ((53'(s2_ff) * 53'(3)) << 16) - (53'(s3_ff) << 1);

   // entries not loaded since the last new reference read as zero
   assign rd_q0 = valid_ff[idx_ff] ? start_mem_ff[idx_ff] : '0;
   assign rd_qf = valid_ff[idx_ff] ? end_mem_ff[idx_ff] : '0;
   assign bs    = $signed({1'b0, b_ff});
   assign dq    = $signed({rd_qf[31], rd_qf}) - $signed({rd_q0[31], rd_q0});
   assign prod  = bs * dq;
   assign last  = ((LW'(idx_ff) + LW'(1)) == loaded_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      valid_in      = valid_ff;
      loaded_in     = loaded_ff;
      start_time_in = start_time_ff;
      duration_in   = duration_ff;
      pv_in         = pv_ff;
      tv_in         = tv_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      rad_in        = rad_ff;
      root_in       = root_ff;
      srem_in       = srem_ff;
      scnt_in       = scnt_ff;
      el_in         = el_ff;
      early_in      = early_ff;
      s_in          = s_ff;
      s2_in         = s2_ff;
      s3_in         = s3_ff;
      b_in          = b_ff;
      idx_in        = idx_ff;
      q0_in         = q0_ff;
      p_in          = p_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      div_req       = '0;
      out_push      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_head;
               if (cmd_head.is_tick) begin
                  state_in = ST_TK_SUB;
               end else if (cmd_head.in_range) begin
                  mem_we    = 1'b1;
                  valid_in  = base_valid | wsel;
                  loaded_in = (j1 > base_loaded) ? j1 : base_loaded;
                  if (cmd_head.new_ref) begin
                     start_time_in = cmd_head.time_now;
                     duration_in   = '0;
                  end
                  state_in = ST_LD_MUL;
               end
            end
         end
         ST_LD_MUL: begin
            pv_in    = 54'(cmd_ff.delta_abs) * 54'(cjt_pkg::VEL_SCALE);
            plo_in   = 64'(cmd_ff.delta_abs) * 64'(cjt_pkg::ACC_SCALE[31:0]);
            state_in = ST_LD_MUL_HI;
         end
         ST_LD_MUL_HI: begin
            phi_in        = 43'(cmd_ff.delta_abs) * 43'(cjt_pkg::ACC_SCALE[42:32]);
            div_req.start = 1'b1;
            div_req.num   = {pv_ff, 31'b0};
            div_req.den   = cjt_pkg::DIV_DW'({cmd_ff.vel, 1'b0});
            div_req.iters = cjt_pkg::TV_ITERS;
            state_in      = ST_LD_WAIT_V;
         end
         ST_LD_WAIT_V: begin
            if (div_rsp.done) begin
               tv_in    = div_rsp.quot[53:0];
               state_in = ST_LD_DIV_A;
            end
         end
         ST_LD_DIV_A: begin
            div_req.start = 1'b1;
            div_req.num   = cjt_pkg::DIV_NW'(plo_ff)
                          + cjt_pkg::DIV_NW'({phi_ff, 32'b0});
            div_req.den   = cjt_pkg::DIV_DW'(cmd_ff.acc);
            div_req.iters = cjt_pkg::TA_ITERS;
            state_in      = ST_LD_WAIT_A;
         end
         ST_LD_WAIT_A: begin
            if (div_rsp.done) begin
               if (|div_rsp.quot[84:80]) begin
                  // root would pass 40 bits: saturate
                  root_in  = '1;
                  state_in = ST_LD_FIN;
               end else begin
                  rad_in   = div_rsp.quot[79:0];
                  root_in  = '0;
                  srem_in  = '0;
                  scnt_in  = cjt_pkg::SQRT_STEPS;
                  state_in = ST_LD_SQRT;
               end
            end
         end
         ST_LD_SQRT: begin
            if (sq_trial >= sq_sub) begin
               srem_in = sq_trial - sq_sub;
               root_in = {root_ff[38:0], 1'b1};
            end else begin
               srem_in = sq_trial;
               root_in = {root_ff[38:0], 1'b0};
            end
            rad_in  = {rad_ff[77:0], 2'b00};
            scnt_in = scnt_ff - 6'd1;
            if (scnt_ff == 6'd1) begin
               state_in = ST_LD_FIN;
            end
         end
         ST_LD_FIN: begin
            duration_in = (tj > duration_ff) ? tj : duration_ff;
            state_in    = ST_IDLE;
         end
         ST_TK_SUB: begin
            el_in    = cmd_ff.time_now - start_time_ff;
            early_in = (cmd_ff.time_now < start_time_ff);
            state_in = ST_TK_CLASS;
         end
         ST_TK_CLASS: begin
            if (duration_ff == '0) begin
               s_in     = cjt_pkg::S_ONE;
               state_in = ST_TK_SQ;
            end else if (early_ff) begin
               s_in     = '0;
               state_in = ST_TK_SQ;
            end else if (el_ff >= duration_ff) begin
               s_in     = cjt_pkg::S_ONE;
               state_in = ST_TK_SQ;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {el_ff, 45'b0};
               div_req.den   = cjt_pkg::DIV_DW'(duration_ff);
               div_req.iters = cjt_pkg::S_ITERS;
               state_in      = ST_TK_WAIT;
            end
         end
         ST_TK_WAIT: begin
            if (div_rsp.done) begin
               s_in     = div_rsp.quot[16:0];
               state_in = ST_TK_SQ;
            end
         end
         ST_TK_SQ: begin
            s2_in    = 34'(s_ff) * 34'(s_ff);
            state_in = ST_TK_CUBE;
         end
         ST_TK_CUBE: begin
            s3_in    = 51'(s2_ff) * 51'(s_ff);
            state_in = ST_TK_BLEND;
         end
         ST_TK_BLEND: begin
            b_in     = blend[48:32];
            idx_in   = '0;
            state_in = (loaded_ff == '0) ? ST_IDLE : ST_TK_MUL;
         end
         ST_TK_MUL: begin
            p_in     = prod;
            q0_in    = rd_q0;
            state_in = ST_TK_EMIT;
         end
         ST_TK_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               idx_in   = idx_ff + JW'(1);
               state_in = last ? ST_IDLE : ST_TK_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         loaded_ff     <= '0;
         start_time_ff <= '0;
         duration_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         loaded_ff     <= loaded_in;
         start_time_ff <= start_time_in;
         duration_ff   <= duration_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      pv_ff    <= pv_in;
      tv_ff    <= tv_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      rad_ff   <= rad_in;
      root_ff  <= root_in;
      srem_ff  <= srem_in;
      scnt_ff  <= scnt_in;
      el_ff    <= el_in;
      early_ff <= early_in;
      s_ff     <= s_in;
      s2_ff    <= s2_in;
      s3_ff    <= s3_in;
      b_ff     <= b_in;
      idx_ff   <= idx_in;
      q0_ff    <= q0_in;
      p_ff     <= p_in;
      if (mem_we) begin
         start_mem_ff[widx] <= cmd_head.start_angle;
         end_mem_ff[widx]   <= cmd_head.end_angle;
      end
   end

   assign out_item.joint_out     = 3'(idx_ff);
   assign out_item.command_angle = q0_ff + p_ff[47:16];
   assign out_item.last_joint    = last;

endmodule

// ----- rtl/cubic_joint_trajectory.sv -----
// top level of the multi-joint cubic trajectory generator
// a load runs two divisions in the back end on the shared
// one-bit-per-cycle divider (54 and 85 steps) and a 40-step square root
// a tick runs a 56-step division (skipped when the phase saturates) and three
// multiply stages, then a multiply and an emit state per loaded joint, the emit
// waiting while the result queue is full; two-entry queues sit on both sides
// reset is synchronous and clears control state, the stored reference and time
module cubic_joint_trajectory #(
   parameter int MAX_JOINTS = cjt_pkg::MAX_JOINTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cjt_pkg::req_type req_item,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output cjt_pkg::rsp_type rsp_item
);

   cjt_pkg::cmd_type     cmd_head;
   logic                 cmd_pop, cmd_empty;
   cjt_pkg::div_req_type div_req;
   cjt_pkg::div_rsp_type div_rsp;
   logic                 out_push, out_full;
   cjt_pkg::rsp_type     out_item;

   cjt_front #(
      .MAX_JOINTS (MAX_JOINTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head)
   );

   cjt_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   cjt_back #(
      .MAX_JOINTS (MAX_JOINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_head  (cmd_head),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   cjt_queue #(
      .WIDTH ($bits(cjt_pkg::rsp_type)),
      .DEPTH (cjt_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_item)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result transfer into a full queue");

   a_no_phantom_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command taken from an empty queue");

endmodule

// ----- bench/tb_top.sv -----
// testbench of the cubic joint trajectory generator: loads and ticks against a predictor
module tb_top;

   localparam int  NJ        = 8;
   localparam longint USEC_L = 1000000;
   localparam longint LIMIT  = 3000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   cjt_pkg::req_type req_item = '0;
   logic    rsp_pop = 1'b0;
   logic    rsp_empty;
   cjt_pkg::rsp_type rsp_item;

   cubic_joint_trajectory dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   // predictor state
   logic signed [31:0] q_start [NJ];
   logic signed [31:0] q_end   [NJ];
   int unsigned        n_loaded;
   logic [39:0]        t_start;
   logic [39:0]        t_span;

   cjt_pkg::rsp_type cmd_queue [$];
   int          errors;
   longint      cycles;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   logic [39:0] clock_us;

   task automatic report(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   function automatic logic [39:0] joint_span(input logic signed [31:0] a0,
                                               input logic signed [31:0] a1,
                                               input logic [30:0] vmax,
                                               input logic [30:0] amax);
      logic [32:0]  d;
      logic [127:0] tv;
      logic [127:0] q;
      logic [127:0] y;
      logic [127:0] c;
      logic [30:0]  v;
      logic [30:0]  a;
      v = (vmax == 0) ? 31'd1 : vmax;
      a = (amax == 0) ? 31'd1 : amax;
      d = ($signed({a1[31], a1}) >= $signed({a0[31], a0})) ?
          ({a1[31], a1} - {a0[31], a0}) : ({a0[31], a0} - {a1[31], a1});
      tv = (128'(d) * 128'd3 * 128'(USEC_L)) / (128'(v) * 128'd2);
      q  = (128'(d) * 128'd6 * 128'(USEC_L) * 128'(USEC_L)) / 128'(a);
      y = 0;
      for (int b = 39; b >= 0; b--) begin
         c = y | (128'd1 << b);
         if (c * c <= q) y = c;
      end
      if (y > tv) tv = y;
      if (tv > 128'hFF_FFFF_FFFF) tv = 128'hFF_FFFF_FFFF;
      return tv[39:0];
   endfunction

   task automatic predict(input cjt_pkg::req_type it);
      logic [16:0]  s;
      logic [39:0]  el;
      logic [63:0]  s2;
      logic [95:0]  bl;
      longint       b;
      longint       p;
      longint       stp;
      logic [39:0]  tj;
      cjt_pkg::rsp_type r;
      if (it.func != cjt_pkg::FUNC_TICK) begin
         if (it.joint_index == 0) begin
            for (int i = 0; i < NJ; i++) begin
               q_start[i] = 0;
               q_end[i] = 0;
            end
            n_loaded = 0;
            t_span = 0;
            t_start = it.time_now;
         end
         q_start[it.joint_index] = it.start_angle;
         q_end[it.joint_index]   = it.end_angle;
         if (it.joint_index + 1 > n_loaded) n_loaded = it.joint_index + 1;
         tj = joint_span(it.start_angle, it.end_angle, it.vel_limit, it.acc_limit);
         if (tj > t_span) t_span = tj;
         return;
      end
      if (t_span == 0) s = cjt_pkg::S_ONE;
      else if (it.time_now < t_start) s = 0;
      else begin
         el = it.time_now - t_start;
         s = (el >= t_span) ? cjt_pkg::S_ONE : 17'((96'(el) << 16) / 96'(t_span));
      end
      s2 = 64'(s) * 64'(s);
      bl = (96'd3 * 96'(s2) * 96'd65536 - 96'd2 * 96'(s2) * 96'(s)) >> 32;
      b = longint'(bl);
      for (int i = 0; i < n_loaded; i++) begin
         p = b * (longint'(q_end[i]) - longint'(q_start[i]));
         stp = (p >= 0) ? (p >>> 16) : -((-p + 65535) >>> 16);
         r.joint_out = i[2:0];
         r.command_angle = 32'(longint'(q_start[i]) + stp);
         r.last_joint = (i + 1 == n_loaded);
         cmd_queue.push_back(r);
      end
   endtask

   // push stays high after a transfer until the next item or an idle cycle
   task automatic send(input cjt_pkg::req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict(it);
   endtask

   function automatic cjt_pkg::req_type make_load(input logic [2:0] j,
                                                  input logic [39:0] t);
      cjt_pkg::req_type it;
      it.func = ~cjt_pkg::FUNC_TICK;
      it.time_now = t;
      it.joint_index = j;
      it.start_angle = $urandom;
      it.end_angle = $urandom;
      // mostly moderate moves and limits, with wide ones now and then
      if ($urandom_range(3) != 0)
         it.end_angle = it.start_angle + $signed($urandom_range(0, 400000)) - 200000;
      it.vel_limit = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 800000));
      it.acc_limit = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 800000));
      return it;
   endfunction

   function automatic cjt_pkg::req_type make_tick(input logic [39:0] t);
      cjt_pkg::req_type it;
      it.func = cjt_pkg::FUNC_TICK;
      it.time_now = t;
      it.joint_index = 3'($urandom);
      it.start_angle = $urandom;
      it.end_angle = $urandom;
      it.vel_limit = 31'($urandom);
      it.acc_limit = 31'($urandom);
      return it;
   endfunction

   task automatic drain();
      req_push <= 1'b0;
      while (cmd_queue.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic test_directed();
      cjt_pkg::req_type it;
      send(make_tick(40'd5));                     // empty reference
      it = make_load(0, 40'd1000);
      it.start_angle = 32'sh8000_0000; it.end_angle = 32'sh7FFF_FFFF;
      it.vel_limit = 0; it.acc_limit = 31'h7FFF_FFFF;
      send(it);
      it = make_load(3, 40'd0);                   // skipped joints stay zero
      it.start_angle = 32'sh7FFF_FFFF; it.end_angle = 32'sh8000_0000;
      it.vel_limit = 31'h7FFF_FFFF; it.acc_limit = 0;
      send(it);
      send(make_tick(40'd0));                     // before the start time
      send(make_tick(40'd1000));
      send(make_tick(40'hFF_FFFF_FFFF));
      it = make_load(0, 40'hFF_FFFF_FFFF);
      it.end_angle = it.start_angle;              // zero duration
      send(it);
      send(make_tick(40'd0));
      it = make_load(0, 40'd0);
      send(it);
      it = make_load(7, 40'd0);
      send(it);
      for (int k = 0; k < 6; k++) send(make_tick(40'($urandom_range(0, 3000000))));
      send(make_tick(40'hFF_FFFF_FFFF));
      drain();                                    // sender waits for all commands
   endtask

   task automatic test_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned nj;
      logic [39:0] t0;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            send(make_tick(40'({$urandom, $urandom})));
            sent++;
         end else begin
            t0 = ($urandom_range(7) == 0) ? 40'({$urandom, $urandom}) : 40'($urandom);
            nj = $urandom_range(1, NJ);
            send(make_load(0, t0));
            for (int j = 1; j < nj; j++)
               send(make_load(($urandom_range(4) == 0) ? 3'($urandom) : j[2:0], t0));
            sent += nj;
            for (int k = 0; k < 4; k++) begin
               send(make_tick(t0 + 40'($urandom_range(0, 4 * 1024 * 1024)) - 40'd1000));
               sent++;
            end
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (cmd_queue.size() == 0) report("command with none expected");
         else begin
            if (rsp_item.joint_out !== cmd_queue[0].joint_out)
               report($sformatf("joint %0d vs %0d", rsp_item.joint_out,
                  cmd_queue[0].joint_out));
            if (rsp_item.command_angle !== cmd_queue[0].command_angle)
               report($sformatf("joint %0d angle %0d vs %0d", rsp_item.joint_out,
                  rsp_item.command_angle, cmd_queue[0].command_angle));
            if (rsp_item.last_joint !== cmd_queue[0].last_joint)
               report($sformatf("joint %0d last flag wrong", rsp_item.joint_out));
            void'(cmd_queue.pop_front());
         end
      end
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      errors = 0;
      cycles = 0;
      n_loaded = 0;
      t_start = 0;
      t_span = 0;
      for (int i = 0; i < NJ; i++) begin
         q_start[i] = 0;
         q_end[i] = 0;
      end
      send_idle_pct = 25;
      recv_idle_pct = 61;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_directed();
      test_random(100);
      send_idle_pct = 61;
      recv_idle_pct = 25;
      test_random(100);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(100);
      drain();
      if (errors == 0 && cmd_queue.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
